[hw/rtl/mmfs_pkg.sv]
`timescale 1ns / 1ps
package mmfs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int VALUE_BITS  = 32;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int FILL_BITS   = ADDR_BITS + 1;
   localparam int DIFF_BITS   = VALUE_BITS + 1;
   localparam int MAG_BITS    = VALUE_BITS + 2;
   localparam int REM_BITS    = VALUE_BITS + 3;
   localparam int STEP_BITS   = $clog2(MAG_BITS);

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LEARN = 2'd1,
      CMD_SCALE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_LOWER_BOUND = 2'd0,
      CSR_UPPER_BOUND = 2'd1,
      CSR_FEATURES    = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CASE_UNSEEN = 3'd0,
      CASE_SINGLE = 3'd1,
      CASE_LOW    = 3'd2,
      CASE_HIGH   = 3'd3,
      CASE_INTERP = 3'd4
   } scale_case_type;

   typedef struct packed {
      logic [1:0]                   cmd;
      logic [7:0]                   feature_index;
      logic signed [VALUE_BITS-1:0] feature_value;
      logic                         row_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] scaled_value;
      logic [2:0]                   scale_case;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hw/rtl/min_max_feature_scaler_core.sv]
`timescale 1ns / 1ps
// Min-max feature scaler.
// Request beats carry a command: clear the table, learn one element of a
// sparse row, or scale one value. Only scale beats produce a response beat.
// A clear empties the whole table at once.
// A learn beat walks its entries one at a time, each with a read and then a
// write back: the skipped indices, its own index and, at row end, the
// remaining indices up to the configured feature count.
// A scale beat that needs no interpolation goes from the table read straight
// to its result; one that does waits for the bit-serial divider with 34 steps.
// The block takes one request at a time and holds req_stall high while busy.
// A finished response sits in an output register; while rsp_stall is high the
// beat is held and the block waits before loading a newer one.
// After reset the table is empty, the bounds are 0 and 1.0, and all 256
// features are in use. There is no clearing pass after reset.
// The user must write configuration through csr_wr_en only while the block is idle; the block does not check it.
module min_max_feature_scaler_core
   import mmfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [VALUE_BITS-1:0] csr_wr_data
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_WALK_RD = 7'b0000010,
      ST_WALK_WR = 7'b0000100,
      ST_SC_RD   = 7'b0001000,
      ST_SC_CMP  = 7'b0010000,
      ST_DIV     = 7'b0100000,
      ST_FIN     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [VALUE_BITS-1:0] lower_ff, lower_in;
   logic signed [VALUE_BITS-1:0] upper_ff, upper_in;
   logic [FILL_BITS-1:0]         fiu_ff, fiu_in;
   logic [FILL_BITS-1:0]         next_fill_ff, next_fill_in;
   logic [TABLE_DEPTH-1:0]       valid_ff, valid_in;

   logic [FILL_BITS-1:0]         cur_ff, cur_in;
   logic [FILL_BITS-1:0]         end_ff, end_in;
   logic [ADDR_BITS-1:0]         own_ff, own_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic                         span_neg_ff, span_neg_in;
   logic signed [VALUE_BITS-1:0] res_ff, res_in;
   logic [2:0]                   kind_ff, kind_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic [ADDR_BITS-1:0]         rd_addr, wr_addr;
   logic                         wr_en;
   logic [VALUE_BITS-1:0]        max_raw, min_raw, max_wdata, min_wdata;
   logic signed [VALUE_BITS-1:0] mx, mn, upd_val;
   logic [FILL_BITS-1:0]         req_next, stop;
   logic signed [DIFF_BITS-1:0]  span, num_s, den_s;
   logic [MAG_BITS-1:0]          mag, quotient, q_res;
   logic                         div_start;
   div_status_type               div_status;

   mmfs_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_max_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (max_wdata),
      .rd_addr (rd_addr),
      .rd_data (max_raw)
   );

   mmfs_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (min_wdata),
      .rd_addr (rd_addr),
      .rd_data (min_raw)
   );

   mmfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mag      (mag),
      .num      (num_s),
      .den      (den_s),
      .status   (div_status),
      .quotient (quotient)
   );

   assign mx      = rd_valid_ff ? signed'(max_raw) : VALUE_MIN;
   assign mn      = rd_valid_ff ? signed'(min_raw) : VALUE_MAX;
   assign upd_val = (cur_ff[ADDR_BITS-1:0] == own_ff) ? val_ff : '0;
   assign max_wdata = (upd_val > mx) ? upd_val : mx;
   assign min_wdata = (upd_val < mn) ? upd_val : mn;
   assign wr_addr = cur_ff[ADDR_BITS-1:0];
   assign wr_en   = (state_ff == ST_WALK_WR);

   assign span  = DIFF_BITS'(upper_ff) - DIFF_BITS'(lower_ff);
   assign num_s = DIFF_BITS'(val_ff) - DIFF_BITS'(mn);
   assign den_s = DIFF_BITS'(mx) - DIFF_BITS'(mn);
   assign mag   = span[DIFF_BITS-1] ? MAG_BITS'(-span) : MAG_BITS'(span);
   assign q_res = span_neg_ff ? MAG_BITS'(lower_ff) - quotient
                              : MAG_BITS'(lower_ff) + quotient;

   assign req_next = FILL_BITS'(req_data.feature_index) + FILL_BITS'(1);
   assign stop     = (fiu_ff > FILL_BITS'(TABLE_DEPTH)) ? FILL_BITS'(TABLE_DEPTH) : fiu_ff;

   always_comb begin
      state_in     = state_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      fiu_in       = fiu_ff;
      next_fill_in = next_fill_ff;
      valid_in     = valid_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      own_in       = own_ff;
      val_in       = val_ff;
      rd_valid_in  = rd_valid_ff;
      span_neg_in  = span_neg_ff;
      res_in       = res_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = cur_ff[ADDR_BITS-1:0];
      div_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOWER_BOUND: lower_in = signed'(csr_wr_data);
            CSR_UPPER_BOUND: upper_in = signed'(csr_wr_data);
            CSR_FEATURES:    fiu_in   = csr_wr_data[FILL_BITS-1:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               own_in = req_data.feature_index;
               val_in = req_data.feature_value;
               unique case (cmd_type'(req_data.cmd))
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     next_fill_in = '0;
                  end
                  CMD_LEARN: begin
                     cur_in = (next_fill_ff <= FILL_BITS'(req_data.feature_index))
                              ? next_fill_ff : FILL_BITS'(req_data.feature_index);
                     end_in = (req_data.row_end && stop > req_next) ? stop : req_next;
                     next_fill_in = req_data.row_end ? '0 : req_next;
                     state_in = ST_WALK_RD;
                  end
                  CMD_SCALE: begin
                     cur_in = req_next;
                     if (req_next >= FILL_BITS'(TABLE_DEPTH)) begin
                        res_in   = '0;
                        kind_in  = CASE_UNSEEN;
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_SC_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK_RD: begin
            rd_valid_in = valid_ff[cur_ff[ADDR_BITS-1:0]];
            state_in    = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            valid_in[cur_ff[ADDR_BITS-1:0]] = 1'b1;
            cur_in = cur_ff + FILL_BITS'(1);
            state_in = (cur_ff + FILL_BITS'(1) >= end_ff) ? ST_IDLE : ST_WALK_RD;
         end
         ST_SC_RD: begin
            rd_valid_in = valid_ff[cur_ff[ADDR_BITS-1:0]];
            state_in    = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            state_in = ST_FIN;
            if (mx == '0) begin
               res_in  = '0;
               kind_in = CASE_UNSEEN;
            end else if (mx == mn) begin
               res_in  = val_ff;
               kind_in = CASE_SINGLE;
            end else if (val_ff <= mn) begin
               res_in  = lower_ff;
               kind_in = CASE_LOW;
            end else if (val_ff >= mx) begin
               res_in  = upper_ff;
               kind_in = CASE_HIGH;
            end else begin
               kind_in     = CASE_INTERP;
               span_neg_in = span[DIFF_BITS-1];
               div_start   = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_in   = signed'(q_res[VALUE_BITS-1:0]);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.scaled_value = res_ff;
               rsp_in.scale_case   = kind_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_ff     <= '0;
         upper_ff     <= VALUE_BITS'(65536);
         fiu_ff       <= FILL_BITS'(TABLE_DEPTH);
         next_fill_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         fiu_ff       <= fiu_in;
         next_fill_ff <= next_fill_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      own_ff      <= own_in;
      val_ff      <= val_in;
      rd_valid_ff <= rd_valid_in;
      span_neg_ff <= span_neg_in;
      res_ff      <= res_in;
      kind_ff     <= kind_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response loaded outside the finish state");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> cur_ff < FILL_BITS'(TABLE_DEPTH))
      else $error("table write beyond the last entry");

endmodule

[hw/rtl/mmfs_ram.sv]
`timescale 1ns / 1ps
module mmfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mmfs_div.sv]
`timescale 1ns / 1ps
module mmfs_div
   import mmfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_BITS-1:0]  mag,
   input  logic [DIFF_BITS-1:0] num,
   input  logic [DIFF_BITS-1:0] den,
   output div_status_type       status,
   output logic [MAG_BITS-1:0]  quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [MAG_BITS-1:0]  mag_ff, mag_in;
   logic [MAG_BITS-1:0]  q_ff, q_in;
   logic [REM_BITS-1:0]  r_ff, r_in;
   logic [DIFF_BITS-1:0] num_ff, num_in;
   logic [DIFF_BITS-1:0] den_ff, den_in;
   logic [REM_BITS-1:0]  r_sum, den_x1, den_x2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      mag_in  = mag_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      den_x1  = REM_BITS'(den_ff);
      den_x2  = REM_BITS'({den_ff, 1'b0});
      r_sum   = {r_ff[REM_BITS-2:0], 1'b0}
                + (mag_ff[MAG_BITS-1] ? REM_BITS'(num_ff) : '0);
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(MAG_BITS - 1);
         mag_in  = mag;
         num_in  = num;
         den_in  = den;
         q_in    = '0;
         r_in    = '0;
      end else if (busy_ff) begin
         mag_in = {mag_ff[MAG_BITS-2:0], 1'b0};
         if (r_sum >= den_x2) begin
            r_in = r_sum - den_x2;
            q_in = {q_ff[MAG_BITS-2:0], 1'b0} + MAG_BITS'(2);
         end else if (r_sum >= den_x1) begin
            r_in = r_sum - den_x1;
            q_in = {q_ff[MAG_BITS-2:0], 1'b0} + MAG_BITS'(1);
         end else begin
            r_in = r_sum;
            q_in = {q_ff[MAG_BITS-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      mag_ff  <= mag_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

[tb/sv/tb_min_max_feature_scaler_core.sv]
`timescale 1ns / 1ps
module tb_min_max_feature_scaler_core;
   import mmfs_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_index = CSR_LOWER_BOUND;
   logic [VALUE_BITS-1:0] csr_wr_data = '0;

   min_max_feature_scaler_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   logic signed [VALUE_BITS-1:0] tbl_max [TABLE_DEPTH];
   logic signed [VALUE_BITS-1:0] tbl_min [TABLE_DEPTH];
   int unsigned                  fill_next;
   logic signed [VALUE_BITS-1:0] bound_lo;
   logic signed [VALUE_BITS-1:0] bound_hi;
   int unsigned                  feature_count;
   rsp_type                      scaled_queue[$];
   int                           error_count = 0;
   bit                           stall_enable = 1'b1;

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void table_clear();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_max[i] = VALUE_MIN;
         tbl_min[i] = VALUE_MAX;
      end
      fill_next = 0;
   endfunction

   function automatic void entry_update(int unsigned i, logic signed [VALUE_BITS-1:0] v);
      if (i >= TABLE_DEPTH) return;
      if (v > tbl_max[i]) tbl_max[i] = v;
      if (v < tbl_min[i]) tbl_min[i] = v;
   endfunction

   function automatic void scaler_predict(req_type r);
      int unsigned e;
      int unsigned stop;
      rsp_type res;
      logic signed [VALUE_BITS+1:0] span;
      logic [MAG_BITS-1:0] mag;
      logic [DIFF_BITS-1:0] num;
      logic [DIFF_BITS-1:0] den;
      logic [127:0] prod;
      logic [63:0] q;
      logic signed [VALUE_BITS+1:0] full;
      case (cmd_type'(r.cmd))
         CMD_CLEAR: table_clear();
         CMD_LEARN: begin
            for (int unsigned i = fill_next; i < r.feature_index && i < TABLE_DEPTH; i++)
               entry_update(i, '0);
            entry_update(r.feature_index, r.feature_value);
            fill_next = r.feature_index + 1;
            if (r.row_end) begin
               stop = feature_count > TABLE_DEPTH ? TABLE_DEPTH : feature_count;
               for (int unsigned i = fill_next; i < stop; i++) entry_update(i, '0);
               fill_next = 0;
            end
         end
         CMD_SCALE: begin
            e = r.feature_index + 1;
            res.scaled_value = '0;
            res.scale_case = CASE_UNSEEN;
            if (e < TABLE_DEPTH && tbl_max[e] != 0) begin
               if (tbl_max[e] == tbl_min[e]) begin
                  res.scaled_value = r.feature_value;
                  res.scale_case = CASE_SINGLE;
               end else if (r.feature_value <= tbl_min[e]) begin
                  res.scaled_value = bound_lo;
                  res.scale_case = CASE_LOW;
               end else if (r.feature_value >= tbl_max[e]) begin
                  res.scaled_value = bound_hi;
                  res.scale_case = CASE_HIGH;
               end else begin
                  span = $signed(bound_hi) - $signed(bound_lo);
                  mag = span < 0 ? -span : span;
                  num = $signed(r.feature_value) - $signed(tbl_min[e]);
                  den = $signed(tbl_max[e]) - $signed(tbl_min[e]);
                  prod = 128'(mag) * 128'(num);
                  q = 64'(prod / 128'(den));
                  full = span < 0 ? $signed(bound_lo) - $signed(q[VALUE_BITS+1:0])
                                  : $signed(bound_lo) + $signed(q[VALUE_BITS+1:0]);
                  res.scaled_value = full[VALUE_BITS-1:0];
                  res.scale_case = CASE_INTERP;
               end
            end
            scaled_queue.push_back(res);
         end
         default: ;
      endcase
   endfunction

   task automatic send_beat(req_type r);
      int unsigned n;
      n = gap_length();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scaler_predict(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scaled_queue.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [VALUE_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LOWER_BOUND: bound_lo = val;
         CSR_UPPER_BOUND: bound_hi = val;
         CSR_FEATURES: feature_count = val[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_req(cmd_type c, int unsigned idx,
                                        logic [31:0] v, bit last);
      req_type r;
      r.cmd = c;
      r.feature_index = idx[7:0];
      r.feature_value = v;
      r.row_end = last;
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_queue.size() == 0) begin
            $error("unexpected response beat %h", rsp_data);
            error_count++;
         end else begin
            rsp_type exp_rsp;
            exp_rsp = scaled_queue.pop_front();
            if (rsp_data.scaled_value !== exp_rsp.scaled_value) begin
               $error("scaled_value expected %h actual %h",
                      exp_rsp.scaled_value, rsp_data.scaled_value);
               error_count++;
            end
            if (rsp_data.scale_case !== exp_rsp.scale_case) begin
               $error("scale_case expected %0d actual %0d",
                      exp_rsp.scale_case, rsp_data.scale_case);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int unsigned n;
      if (stall_enable) begin
         n = gap_length();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
      rsp_stall <= 1'b0;
   end

   task automatic test_directed();
      send_beat(make_req(CMD_SCALE, 3, 32'h0001_0000, 0));
      send_beat(make_req(CMD_LEARN, 0, 32'h0002_0000, 0));
      send_beat(make_req(CMD_LEARN, 2, VALUE_MAX, 0));
      send_beat(make_req(CMD_LEARN, 5, VALUE_MIN, 0));
      send_beat(make_req(CMD_LEARN, 1, 32'hFFFF_0000, 1));
      send_beat(make_req(CMD_LEARN, 255, 32'h0003_0000, 1));
      send_beat(make_req(CMD_SCALE, 1, 32'h0000_8000, 0));
      send_beat(make_req(CMD_SCALE, 1, VALUE_MAX, 0));
      send_beat(make_req(CMD_SCALE, 1, VALUE_MIN, 0));
      send_beat(make_req(CMD_SCALE, 4, 32'h1234_5678, 0));
      send_beat(make_req(CMD_SCALE, 0, 32'h0000_4000, 0));
      send_beat(make_req(CMD_SCALE, 255, 32'h0000_4000, 0));
      send_beat(make_req(CMD_SCALE, 254, 32'h0000_4000, 0));
      send_beat(make_req(CMD_NONE, 7, 32'hFFFF_FFFF, 1));
      send_beat(make_req(CMD_CLEAR, 255, 0, 1));
      send_beat(make_req(CMD_SCALE, 2, 32'h0000_4000, 0));
      wait_drained();
   endtask

   task automatic test_config(logic [31:0] lo, logic [31:0] hi, logic [8:0] feats);
      write_csr(CSR_LOWER_BOUND, lo);
      write_csr(CSR_UPPER_BOUND, hi);
      write_csr(CSR_FEATURES, {23'd0, feats});
   endtask

   task automatic test_random_rows(int unsigned beats);
      int unsigned sent;
      int unsigned idx;
      sent = 0;
      send_beat(make_req(CMD_CLEAR, $urandom_range(0, 255), $urandom(), $urandom_range(0, 1)));
      while (sent < beats) begin
         case ($urandom_range(0, 9))
            0: begin
               send_beat(make_req(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                                  $urandom(), $urandom_range(0, 1)));
               sent++;
            end
            1, 2, 3, 4: begin
               idx = $urandom_range(0, 12);
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 255);
                  send_beat(make_req(CMD_LEARN, idx, rand_value(), 0));
                  idx += $urandom_range(1, 5);
                  sent++;
               end
               send_beat(make_req(CMD_LEARN, idx > 255 ? 255 : idx, rand_value(), 1));
               sent++;
            end
            default: begin
               send_beat(make_req(CMD_SCALE, $urandom_range(0, 9) == 0 ?
                                  $urandom_range(0, 255) : $urandom_range(0, 24),
                                  rand_value(), $urandom_range(0, 1)));
               sent++;
            end
         endcase
      end
      wait_drained();
   endtask

   task automatic test_pause();
      stall_enable = 1'b0;
      send_beat(make_req(CMD_LEARN, 1, 32'h0000_1000, 1));
      send_beat(make_req(CMD_SCALE, 0, 32'h0000_0800, 0));
      wait_drained();
      send_beat(make_req(CMD_SCALE, 0, 32'h0000_0400, 0));
      stall_enable = 1'b1;
      wait_drained();
   endtask

   initial begin
      bound_lo = 0;
      bound_hi = 32'h0001_0000;
      feature_count = 256;
      table_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config(32'hFFFF_0000, 32'h0001_0000, 9'd16);
      test_random_rows(400);
      test_config(VALUE_MIN, VALUE_MAX, 9'd1);
      test_random_rows(300);
      test_config(VALUE_MAX, VALUE_MIN, 9'd0);
      test_random_rows(300);
      test_pause();
      test_config(32'h0005_0000, 32'hFFFB_0000, 9'd511);
      test_random_rows(300);
      test_config(32'h0000_0000, 32'h0001_0000, 9'd256);
      test_random_rows(300);
      if (error_count == 0 && scaled_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
